>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is clocked on aclk and
// is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int ROOMS_PER_SIDE_DEF = 16;

    localparam int START_W = 4;
    localparam int DIR_W   = 2;
    localparam int CELL_W  = 6;
    localparam int KIND_W  = 2;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROOM   = 2'd0,
        KIND_WALL   = 2'd1,
        KIND_GOAL   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    // Datapath operation selected by the current microcode word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_CLEAR,
        OP_START,
        OP_PROBE_INIT,
        OP_PROBE_RD,
        OP_PROBE_STEP,
        OP_POP_RD,
        OP_POP_LOAD,
        OP_TRY_RD,
        OP_CARVE,
        OP_EMIT_ROOM,
        OP_EMIT_GOAL,
        OP_UNUSED
    } op_t;

    // Jump condition of a microcode word.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_MODE_START,
        C_NOT_RUNNING,
        C_SP_ZERO,
        C_OPEN_FOUND,
        C_PROBE_MORE,
        C_CLR_MORE,
        C_NB_INVALID,
        C_NB_VISITED,
        C_NOT_DONE
    } cond_t;

    typedef struct packed {
        op_t  op;
        logic wait_in;
        logic emit;
    } ctrl_t;

    typedef struct packed {
        logic stall;
        logic mode_start;
        logic not_running;
        logic sp_zero;
        logic open_found;
        logic probe_more;
        logic clr_more;
        logic nb_invalid;
        logic nb_visited;
        logic not_done;
    } status_t;

endpackage

>>> hw/rtl/dmc_ram.sv
`timescale 1ns / 1ps

module dmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dmc_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dmc_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  dmc_pkg::status_t st,
    output dmc_pkg::ctrl_t   ctrl
);

    import dmc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'd0,
        S_DRAW    = 4'd1,
        S_BT      = 4'd2,
        S_PROBE   = 4'd3,
        S_EVAL    = 4'd4,
        S_EVAL2   = 4'd5,
        S_POP     = 4'd6,
        S_POP_LD  = 4'd7,
        S_TRY     = 4'd8,
        S_TRY_EV  = 4'd9,
        S_CARVE   = 4'd10,
        S_ROOM    = 4'd11,
        S_GOAL    = 4'd12,
        S_UNUSED  = 4'd13,
        S_CLEAR   = 4'd14,
        S_START   = 4'd15
    } step_t;

    typedef struct packed {
        op_t   op;
        logic  wait_in;
        logic  emit;
        cond_t cond;
        step_t target;
    } uword_t;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   take;

    // Microcode program: one word per step.
    function automatic uword_t rom(input step_t pc);
        uword_t w;
        w = '{OP_NONE, 1'b0, 1'b0, C_NEVER, S_IDLE};
        case (pc)
            S_IDLE:   w = '{OP_ACCEPT,     1'b1, 1'b0, C_MODE_START,  S_CLEAR};
            S_DRAW:   w = '{OP_NONE,       1'b0, 1'b0, C_NOT_RUNNING, S_UNUSED};
            S_BT:     w = '{OP_PROBE_INIT, 1'b0, 1'b0, C_SP_ZERO,     S_TRY};
            S_PROBE:  w = '{OP_PROBE_RD,   1'b0, 1'b0, C_NEVER,       S_IDLE};
            S_EVAL:   w = '{OP_PROBE_STEP, 1'b0, 1'b0, C_OPEN_FOUND,  S_TRY};
            S_EVAL2:  w = '{OP_NONE,       1'b0, 1'b0, C_PROBE_MORE,  S_PROBE};
            S_POP:    w = '{OP_POP_RD,     1'b0, 1'b0, C_NEVER,       S_IDLE};
            S_POP_LD: w = '{OP_POP_LOAD,   1'b0, 1'b0, C_ALWAYS,      S_BT};
            S_TRY:    w = '{OP_TRY_RD,     1'b0, 1'b0, C_NB_INVALID,  S_UNUSED};
            S_TRY_EV: w = '{OP_NONE,       1'b0, 1'b0, C_NB_VISITED,  S_UNUSED};
            S_CARVE:  w = '{OP_CARVE,      1'b0, 1'b1, C_NEVER,       S_IDLE};
            S_ROOM:   w = '{OP_EMIT_ROOM,  1'b0, 1'b1, C_NOT_DONE,    S_IDLE};
            S_GOAL:   w = '{OP_EMIT_GOAL,  1'b0, 1'b1, C_ALWAYS,      S_IDLE};
            S_UNUSED: w = '{OP_UNUSED,     1'b0, 1'b1, C_ALWAYS,      S_IDLE};
            S_CLEAR:  w = '{OP_CLEAR,      1'b0, 1'b0, C_CLR_MORE,    S_CLEAR};
            S_START:  w = '{OP_START,      1'b0, 1'b1, C_ALWAYS,      S_IDLE};
            default:  w = '{OP_NONE,       1'b0, 1'b0, C_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

    always_comb begin
        uw = rom(pc_reg);
        case (uw.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_MODE_START:  take = st.mode_start;
            C_NOT_RUNNING: take = st.not_running;
            C_SP_ZERO:     take = st.sp_zero;
            C_OPEN_FOUND:  take = st.open_found;
            C_PROBE_MORE:  take = st.probe_more;
            C_CLR_MORE:    take = st.clr_more;
            C_NB_INVALID:  take = st.nb_invalid;
            C_NB_VISITED:  take = st.nb_visited;
            C_NOT_DONE:    take = st.not_done;
            default:       take = 1'b0;
        endcase
        if (st.stall) begin
            pc_next = pc_reg;
        end else if (take) begin
            pc_next = uw.target;
        end else begin
            pc_next = step_t'(pc_reg + 4'd1);
        end
    end

    assign ctrl = '{uw.op, uw.wait_in, uw.emit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    `ASSERT_NEXT(a_stall_holds_pc, st.stall, $stable(pc_reg), "step advanced while stalled")
    `ASSERT_NEXT(a_start_enters_clear, (pc_reg == S_IDLE) && !st.stall && st.mode_start,
        pc_reg == S_CLEAR, "start transaction did not begin the clearing sweep")
    `ASSERT_NEXT(a_clear_ends_in_start, (pc_reg == S_CLEAR) && !st.stall && !st.clr_more,
        pc_reg == S_START, "clearing sweep did not end in the start step")

endmodule

>>> hw/rtl/dfs_maze_carver_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Start transaction: clears the visited RAM before use, then marks and emits the start room.
// Draw transaction: when idle or complete, emits unused; else, unless the stack is empty,
// backtracks, probing and popping until a neighbor is open, then tries the direction: off the
// lattice or into a visited room emits unused, else emits the carved wall, the room and, on
// completion, the goal; a busy result stalls. One transaction is in work at a time. Reset
// (aresetn, synchronous, active low) idles the sequencer and clears depth, counts and position.
module dfs_maze_carver_core #(
    parameter int ROOMS_PER_SIDE = dmc_pkg::ROOMS_PER_SIDE_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_mode,
    input  logic [dmc_pkg::START_W-1:0] s_start_x,
    input  logic [dmc_pkg::START_W-1:0] s_start_y,
    input  logic [dmc_pkg::DIR_W-1:0]   s_direction,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [dmc_pkg::CELL_W-1:0]  m_cell_row,
    output logic [dmc_pkg::CELL_W-1:0]  m_cell_col,
    output logic [dmc_pkg::KIND_W-1:0]  m_kind,
    output logic                        m_complete,
    output logic                        m_last
);

    import dmc_pkg::*;

    // Room coordinate width, RAM address width ({y, x}) and counter width.
    localparam int CW         = $clog2(ROOMS_PER_SIDE);
    localparam int AW         = 2 * CW;
    localparam int DEPTH      = 1 << AW;
    localparam int ROOM_COUNT = ROOMS_PER_SIDE * ROOMS_PER_SIDE;
    localparam int NW         = AW + 1;

    localparam logic [CW:0]   SIDE    = (CW + 1)'(ROOMS_PER_SIDE);
    localparam logic [CW-1:0] MAX_C   = CW'(ROOMS_PER_SIDE - 1);
    localparam logic [NW-1:0] RC_N    = NW'(ROOM_COUNT);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    ctrl_t   ctrl;
    status_t st;

    // Transaction and walk state.
    logic [CW-1:0]    start_x_reg, start_x_next;
    logic [CW-1:0]    start_y_reg, start_y_next;
    logic [DIR_W-1:0] dir_reg, dir_next;
    logic [CW-1:0]    cur_x_reg, cur_x_next;
    logic [CW-1:0]    cur_y_reg, cur_y_next;
    logic [CW-1:0]    nx_reg, nx_next;
    logic [CW-1:0]    ny_reg, ny_next;
    logic [DIR_W-1:0] probe_dir_reg, probe_dir_next;
    logic             probe_ok_reg, probe_ok_next;
    logic [NW-1:0]    sp_reg, sp_next;
    logic [NW-1:0]    rooms_reg, rooms_next;
    logic             running_reg, running_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    logic [CELL_W-1:0] m_cell_row_reg, m_cell_row_next;
    logic [CELL_W-1:0] m_cell_col_reg, m_cell_col_next;
    kind_t             m_kind_reg, m_kind_next;
    logic              m_complete_reg, m_complete_next;
    logic              m_last_reg, m_last_next;

    // RAM ports.
    logic          vis_we, vis_re, vis_wdata, vis_rdata;
    logic [AW-1:0] vis_waddr, vis_raddr;
    logic          stk_we, stk_re;
    logic [AW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // Neighbour unit, shared by the backtrack probes and the draw.
    logic [DIR_W-1:0] nb_dir;
    logic             nb_ok;
    logic [CW-1:0]    nb_x, nb_y;

    logic          out_free, stall, done;
    logic [NW-1:0] sp_dec, rooms_inc;
    logic [CW-1:0] sat_x, sat_y;

    function automatic logic [CELL_W-1:0] to_cell(input logic [CW:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[CELL_W-1:0];
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign stall     = (ctrl.wait_in && !s_valid) || (ctrl.emit && !out_free);
    assign done      = rooms_reg >= RC_N;
    assign sp_dec    = sp_reg - ONE_N;
    assign rooms_inc = rooms_reg + ONE_N;

    // Saturate an out-of-range start room to the last row or column.
    assign sat_x = (32'(s_start_x) >= ROOMS_PER_SIDE) ? MAX_C : CW'(s_start_x);
    assign sat_y = (32'(s_start_y) >= ROOMS_PER_SIDE) ? MAX_C : CW'(s_start_y);

    assign nb_dir = (ctrl.op == OP_TRY_RD) ? dir_reg : probe_dir_reg;

    always_comb begin
        nb_ok = 1'b0;
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        case (nb_dir)
            DIR_UP: begin
                if (cur_y_reg != '0) begin
                    nb_ok = 1'b1;
                    nb_y  = cur_y_reg - 1'b1;
                end
            end
            DIR_DOWN: begin
                if ((CW + 1)'(cur_y_reg) + 1'b1 < SIDE) begin
                    nb_ok = 1'b1;
                    nb_y  = cur_y_reg + 1'b1;
                end
            end
            DIR_LEFT: begin
                if (cur_x_reg != '0) begin
                    nb_ok = 1'b1;
                    nb_x  = cur_x_reg - 1'b1;
                end
            end
            default: begin
                if ((CW + 1)'(cur_x_reg) + 1'b1 < SIDE) begin
                    nb_ok = 1'b1;
                    nb_x  = cur_x_reg + 1'b1;
                end
            end
        endcase
    end

    // Sequencer status.
    always_comb begin
        st.stall       = stall;
        st.mode_start  = !s_mode;
        st.not_running = !running_reg;
        st.sp_zero     = (sp_reg == '0);
        st.open_found  = probe_ok_reg && !vis_rdata;
        st.probe_more  = (probe_dir_reg != '0);
        st.clr_more    = (clr_addr_reg != '1);
        st.nb_invalid  = !nb_ok;
        st.nb_visited  = vis_rdata;
        st.not_done    = !done;
    end

    dmc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .st      (st),
        .ctrl    (ctrl)
    );

    // Datapath driven by the current control word.
    always_comb begin
        start_x_next   = start_x_reg;
        start_y_next   = start_y_reg;
        dir_next       = dir_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        probe_dir_next = probe_dir_reg;
        probe_ok_next  = probe_ok_reg;
        sp_next        = sp_reg;
        rooms_next     = rooms_reg;
        running_next   = running_reg;
        clr_addr_next  = clr_addr_reg;

        vis_we    = 1'b0;
        vis_waddr = {ny_reg, nx_reg};
        vis_wdata = 1'b0;
        vis_re    = 1'b0;
        vis_raddr = {nb_y, nb_x};
        stk_we    = 1'b0;
        stk_waddr = sp_reg[AW-1:0];
        stk_wdata = {cur_y_reg, cur_x_reg};
        stk_re    = 1'b0;
        stk_raddr = sp_dec[AW-1:0];

        // Drop the result once taken; a new one may load in the same cycle.
        m_valid_next    = m_valid_reg && !m_ready;
        m_cell_row_next = m_cell_row_reg;
        m_cell_col_next = m_cell_col_reg;
        m_kind_next     = m_kind_reg;
        m_complete_next = m_complete_reg;
        m_last_next     = m_last_reg;

        if (!stall) begin
            case (ctrl.op)
                OP_ACCEPT: begin
                    start_x_next = sat_x;
                    start_y_next = sat_y;
                    dir_next     = s_direction;
                end
                OP_CLEAR: begin
                    vis_we        = 1'b1;
                    vis_waddr     = clr_addr_reg;
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
                OP_START: begin
                    vis_we          = 1'b1;
                    vis_waddr       = {start_y_reg, start_x_reg};
                    vis_wdata       = 1'b1;
                    cur_x_next      = start_x_reg;
                    cur_y_next      = start_y_reg;
                    sp_next         = '0;
                    rooms_next      = ONE_N;
                    running_next    = ONE_N < RC_N;
                    m_valid_next    = 1'b1;
                    m_cell_row_next = to_cell({start_y_reg, 1'b1});
                    m_cell_col_next = to_cell({start_x_reg, 1'b1});
                    m_kind_next     = KIND_ROOM;
                    m_complete_next = !(ONE_N < RC_N);
                    m_last_next     = 1'b1;
                end
                OP_PROBE_INIT: begin
                    probe_dir_next = '0;
                end
                OP_PROBE_RD: begin
                    vis_re        = 1'b1;
                    probe_ok_next = nb_ok;
                end
                OP_PROBE_STEP: begin
                    probe_dir_next = probe_dir_reg + 1'b1;
                end
                OP_POP_RD: begin
                    stk_re  = 1'b1;
                    sp_next = sp_dec;
                end
                OP_POP_LOAD: begin
                    cur_x_next = stk_rdata[CW-1:0];
                    cur_y_next = stk_rdata[AW-1:CW];
                end
                OP_TRY_RD: begin
                    vis_re  = 1'b1;
                    nx_next = nb_x;
                    ny_next = nb_y;
                end
                OP_CARVE: begin
                    vis_we    = 1'b1;
                    vis_wdata = 1'b1;
                    if (sp_reg < RC_N) begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + ONE_N;
                    end
                    cur_x_next      = nx_reg;
                    cur_y_next      = ny_reg;
                    rooms_next      = rooms_inc;
                    m_valid_next    = 1'b1;
                    m_cell_row_next = to_cell((CW + 1)'(cur_y_reg) + (CW + 1)'(ny_reg) + 1'b1);
                    m_cell_col_next = to_cell((CW + 1)'(cur_x_reg) + (CW + 1)'(nx_reg) + 1'b1);
                    m_kind_next     = KIND_WALL;
                    m_complete_next = rooms_inc >= RC_N;
                    m_last_next     = 1'b0;
                end
                OP_EMIT_ROOM: begin
                    m_valid_next    = 1'b1;
                    m_cell_row_next = to_cell({cur_y_reg, 1'b1});
                    m_cell_col_next = to_cell({cur_x_reg, 1'b1});
                    m_kind_next     = KIND_ROOM;
                    m_complete_next = done;
                    m_last_next     = !done;
                end
                OP_EMIT_GOAL: begin
                    running_next    = 1'b0;
                    m_valid_next    = 1'b1;
                    m_cell_row_next = to_cell({cur_y_reg, 1'b1});
                    m_cell_col_next = to_cell({cur_x_reg, 1'b1});
                    m_kind_next     = KIND_GOAL;
                    m_complete_next = 1'b1;
                    m_last_next     = 1'b1;
                end
                OP_UNUSED: begin
                    m_valid_next    = 1'b1;
                    m_cell_row_next = to_cell({cur_y_reg, 1'b1});
                    m_cell_col_next = to_cell({cur_x_reg, 1'b1});
                    m_kind_next     = KIND_UNUSED;
                    m_complete_next = done;
                    m_last_next     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    dmc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_visited (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    dmc_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            sp_reg       <= '0;
            rooms_reg    <= '0;
            running_reg  <= 1'b0;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            sp_reg       <= sp_next;
            rooms_reg    <= rooms_next;
            running_reg  <= running_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge aclk) begin
        start_x_reg    <= start_x_next;
        start_y_reg    <= start_y_next;
        dir_reg        <= dir_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        probe_dir_reg  <= probe_dir_next;
        probe_ok_reg   <= probe_ok_next;
        m_cell_row_reg <= m_cell_row_next;
        m_cell_col_reg <= m_cell_col_next;
        m_kind_reg     <= m_kind_next;
        m_complete_reg <= m_complete_next;
        m_last_reg     <= m_last_next;
    end

    assign s_ready    = ctrl.wait_in;
    assign m_valid    = m_valid_reg;
    assign m_cell_row = m_cell_row_reg;
    assign m_cell_col = m_cell_col_reg;
    assign m_kind     = m_kind_reg;
    assign m_complete = m_complete_reg;
    assign m_last     = m_last_reg;

    // Every pushed room was visited before the current one.
    `ASSERT_ALWAYS(a_stack_below_rooms, !running_reg || (sp_reg < rooms_reg),
        "stack depth reached the visited room count")
    `ASSERT_ALWAYS(a_goal_is_final, !m_valid_reg || (m_kind_reg != KIND_GOAL)
        || (m_complete_reg && m_last_reg), "goal result not marked complete and last")
    `ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "sequencer stayed idle after accepting a transaction")

endmodule
